### hdl/pwd_pkg.sv
`timescale 1ns / 1ps
package pwd_pkg;
    typedef enum logic [2:0] {
        FAM_10H = 3'd0, FAM_11H = 3'd1, FAM_12H = 3'd2, FAM_14H = 3'd3,
        FAM_15H = 3'd4, FAM_16H = 3'd5, FAM_17H = 3'd6, FAM_NONE = 3'd7
    } family_t;

    localparam logic [1:0] REG_FAMILY = 2'd0;
    localparam logic [1:0] REG_MODEL  = 2'd1;
    localparam logic [1:0] REG_PVI    = 2'd2;
    localparam logic [1:0] REG_PLL    = 2'd3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 128;
    // pipelined divider depth, one stage per quotient bit of a 16-bit numerator
    localparam int LAT_DIV    = 16;

    typedef struct packed {
        logic [2:0] family_sel;
        logic [7:0] cpu_model;
        logic       pvi_mode;
        logic [5:0] main_pll_freq_id;
    } cfg_t;

    typedef struct packed {
        logic        enabled;
        logic [7:0]  freq_id;
        logic [5:0]  div_id;
        logic [7:0]  volt_id;
        logic [15:0] multiplier_x100;
        logic [15:0] core_mhz;
        logic signed [13:0] core_mv_x4;
        logic [6:0]  nb_volt_id;
        logic signed [13:0] nb_mv_x4;
        logic [15:0] current_x100;
        logic [19:0] power_mw;
        logic        current_valid;
    } result_t;

    // step in quarter mV: fine = 0 gives 50 (12.5mV), fine = 1 gives 25 (6.25mV)
    function automatic logic signed [13:0] vid_to_mv4(input logic [7:0] vid,
                                                      input cfg_t cfg);
        logic [7:0] v;
        logic fine;
        fine = 1'b0;
        v = vid;
        if (cfg.family_sel == FAM_10H) begin
            if (cfg.pvi_mode) begin
                if (vid < 8'd32) return 14'(15'sd6200 - $signed({7'd0, vid}) * 15'sd100);
                v = (vid > 8'd63) ? 8'd63 : vid;
                return 14'(15'sd4650 - $signed({7'd0, v}) * 15'sd50);
            end
            v = (vid > 8'd124) ? 8'd124 : vid;
        end else begin
            fine = (cfg.family_sel == FAM_17H) || (cfg.family_sel == FAM_14H) ||
                   ((cfg.family_sel == FAM_15H) &&
                    ((cfg.cpu_model[7:4] == 4'h1) || (cfg.cpu_model[7:4] == 4'h3)));
        end
        if (fine) return 14'(15'sd6200 - $signed({7'd0, v}) * 15'sd25);
        return 14'(15'sd6200 - $signed({7'd0, v}) * 15'sd50);
    endfunction
endpackage

### hdl/pwd_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage.
module pwd_div #(
    parameter int NW = 16,
    parameter int DW = 9
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [NW-1:0] quo
);
    for (genvar i = 0; i < NW; i++) begin : g_st
        logic [NW-1:0] q_in;
        logic [DW:0]   r_in;
        logic [DW-1:0] d_in;
        logic [DW+1:0] sh;
        logic [DW+1:0] df;
        logic [NW-1:0] q_reg;
        logic [DW-1:0] d_reg;
        if (i == 0) begin : g_src
            assign q_in = num;
            assign r_in = '0;
            assign d_in = den;
        end else begin : g_src
            assign q_in = g_st[i-1].q_reg;
            assign r_in = g_st[i-1].g_rem.r_reg;
            assign d_in = g_st[i-1].d_reg;
        end
        always_comb begin
            sh = {r_in, q_in[NW-1]};
            df = sh - {2'b00, d_in};
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                d_reg <= d_in;
                q_reg <= {q_in[NW-2:0], !df[DW+1]};
            end
        end
        if (i < NW - 1) begin : g_rem
            logic [DW:0] r_reg;
            always_ff @(posedge aclk) begin
                if (en) r_reg <= df[DW+1] ? sh[DW:0] : df[DW:0];
            end
        end
    end

    assign quo = (g_st[NW-1].d_reg == '0) ? '0 : g_st[NW-1].q_reg;
endmodule

### hdl/pstate_word_decoder_core.sv
`timescale 1ns / 1ps
// Pipeline: field and operand stages, a 16-stage pipelined divider, the output
// register.
// Throughput: one item per cycle; the whole pipe advances when the output
// register is empty or being taken.
// Reset: aresetn synchronous active low clears valid bits and config registers.
module pstate_word_decoder_core
    import pwd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // msr_word
    input  logic                  s_axis_tuser,  // is_definition
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // enabled, freq_id, div_id, volt_id, multiplier_x100, core_mhz, core_mv_x4,
    // nb_volt_id, nb_mv_x4, current_x100, power_mw, current_valid, zero pad
    output logic [M_TDATA_W-1:0]  m_axis_tdata
);
    localparam int NST = LAT_DIV + 2;

    cfg_t cfg_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_FAMILY: cfg_reg.family_sel <= cfg_data[2:0];
                REG_MODEL:  cfg_reg.cpu_model <= cfg_data;
                REG_PVI:    cfg_reg.pvi_mode <= cfg_data[0];
                REG_PLL:    cfg_reg.main_pll_freq_id <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    logic out_v_reg;
    logic adv;
    assign adv = !out_v_reg || m_axis_tready;
    assign s_axis_tready = adv;

    logic [NST-1:0] v_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
            out_v_reg <= 1'b0;
        end else if (adv) begin
            v_reg <= {v_reg[NST-2:0], s_axis_tvalid};
            out_v_reg <= v_reg[NST-1];
        end
    end
    assign m_axis_tvalid = out_v_reg;

    // stage 1: field extraction
    logic [63:0] w;
    logic [7:0] fid, vid, iv;
    logic [5:0] did;
    logic [1:0] idv;
    always_comb begin
        w = s_axis_tdata;
        fid = {2'b0, w[5:0]}; did = {3'b0, w[8:6]}; vid = {1'b0, w[15:9]};
        iv = w[39:32]; idv = w[41:40];
        unique case (family_t'(cfg_reg.family_sel))
            FAM_17H: begin
                fid = w[7:0]; did = w[13:8]; vid = w[21:14];
                iv = w[29:22]; idv = w[31:30];
            end
            FAM_12H: begin fid = {3'b0, w[8:4]}; did = {2'b0, w[3:0]}; end
            FAM_14H: begin fid = {4'b0, w[3:0]}; did = {1'b0, w[8:4]}; end
            default: ;
        endcase
    end

    logic [7:0] f1_reg, vid1_reg, iv1_reg;
    logic [5:0] d1_reg;
    logic [1:0] idv1_reg;
    logic [6:0] nbv1_reg;
    logic en1_reg, def1_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            f1_reg <= fid; d1_reg <= did; vid1_reg <= vid;
            iv1_reg <= iv; idv1_reg <= idv;
            nbv1_reg <= ((cfg_reg.family_sel == FAM_10H) ||
                         (cfg_reg.family_sel == FAM_11H)) ? w[31:25] : 7'd0;
            def1_reg <= s_axis_tuser;
            en1_reg <= s_axis_tuser ? w[63] : 1'b1;
        end
    end

    // stage 2: numerators, denominators, voltages, current
    logic [15:0] num_m, num_c;
    logic [8:0] den_m, den_c;
    logic [15:0] cur;
    logic cvalid;
    logic [8:0] fb;
    always_comb begin
        fb = (cfg_reg.family_sel == FAM_11H) ? 9'(f1_reg) + 9'd8 : 9'(f1_reg) + 9'd16;
        num_m = '0; den_m = 9'd1; num_c = '0; den_c = 9'd1;
        unique case (family_t'(cfg_reg.family_sel))
            FAM_10H, FAM_11H, FAM_15H, FAM_16H: begin
                num_m = 16'(fb * 7'd100);
                den_m = 9'd2 << d1_reg[2:0];
                num_c = 16'(fb * 7'd100);
                den_c = 9'd1 << d1_reg[2:0];
            end
            FAM_12H: begin
                num_m = 16'(fb * 7'd100);
                num_c = num_m;
                case (d1_reg[3:0])
                    4'd1: begin num_m = 16'(fb * 8'd200); den_m = 9'd3; end
                    4'd2: den_m = 9'd2;
                    4'd3: den_m = 9'd3;
                    4'd4: den_m = 9'd4;
                    4'd5: den_m = 9'd6;
                    4'd6: den_m = 9'd8;
                    4'd7: den_m = 9'd12;
                    4'd8: den_m = 9'd16;
                    default: den_m = 9'd1;
                endcase
                num_c = num_m; den_c = den_m;
            end
            FAM_17H: begin
                num_m = 16'(f1_reg) * 16'd200;
                den_m = 9'(d1_reg);
                num_c = num_m;
                den_c = (f1_reg == 8'd0) ? 9'd0 : 9'(d1_reg);
            end
            FAM_14H: begin
                num_c = 16'((11'(cfg_reg.main_pll_freq_id) + 11'd16) * 11'd400);
                den_c = 9'(d1_reg) * 9'd4 + 9'(f1_reg) + 9'd4;
                den_m = 9'd0;
            end
            default: begin den_m = 9'd0; den_c = 9'd0; end
        endcase
        cvalid = def1_reg && (idv1_reg != 2'd3);
        if (cfg_reg.family_sel == FAM_17H)
            cur = 16'((9'(iv1_reg) + ((idv1_reg == 2'd0) ? 9'd1 :
                       (idv1_reg == 2'd1) ? 9'd10 : 9'd100)) * 9'd100);
        else
            cur = (idv1_reg == 2'd0) ? 16'(iv1_reg) * 16'd100 :
                  (idv1_reg == 2'd1) ? 16'(iv1_reg) * 16'd10 : 16'(iv1_reg);
        if (!cvalid) cur = '0;
    end

    logic [15:0] nm2_reg, nc2_reg, cur2_reg;
    logic [8:0] dm2_reg, dc2_reg;
    logic signed [13:0] mv2_reg, nbmv2_reg;
    logic cv2_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            nm2_reg <= num_m; dm2_reg <= den_m; nc2_reg <= num_c; dc2_reg <= den_c;
            mv2_reg <= vid_to_mv4(vid1_reg, cfg_reg);
            nbmv2_reg <= (nbv1_reg != 7'd0 || cfg_reg.family_sel == FAM_10H ||
                          cfg_reg.family_sel == FAM_11H) ?
                         vid_to_mv4({1'b0, nbv1_reg}, cfg_reg) : 14'sd0;
            cur2_reg <= cur; cv2_reg <= cvalid;
        end
    end

    // stage 3: power product; x/400 by reciprocal multiply in the next stage
    logic signed [31:0] prod3_reg;
    always_ff @(posedge aclk) begin
        if (adv) prod3_reg <= $signed({1'b0, cur2_reg}) * mv2_reg;
    end

    // dividers and delay lines
    logic [15:0] mult_q, mhz_q;
    pwd_div #(.NW(16), .DW(9)) u_div_m (.aclk(aclk), .en(adv), .num(nm2_reg),
                                        .den(dm2_reg), .quo(mult_q));
    pwd_div #(.NW(16), .DW(9)) u_div_c (.aclk(aclk), .en(adv), .num(nc2_reg),
                                        .den(dc2_reg), .quo(mhz_q));

    typedef struct packed {
        logic        en;
        logic [7:0]  f;
        logic [5:0]  d;
        logic [7:0]  v;
        logic [6:0]  nbv;
    } id_t;
    typedef struct packed {
        logic signed [13:0] mv;
        logic signed [13:0] nbmv;
        logic [15:0] cur;
        logic        cv;
    } late_t;

    id_t id_pipe_reg [LAT_DIV+1];
    late_t lt_pipe_reg [LAT_DIV];
    logic [19:0] pw_pipe_reg [LAT_DIV-1];
    always_ff @(posedge aclk) begin
        if (adv) begin
            id_pipe_reg[0] <= '{en1_reg, f1_reg, d1_reg, vid1_reg, nbv1_reg};
            lt_pipe_reg[0] <= '{mv2_reg, nbmv2_reg, cur2_reg, cv2_reg};
            pw_pipe_reg[0] <= (prod3_reg <= 0) ? 20'd0 :
                              20'((prod3_reg * 64'sd2748779070) >>> 40);
            for (int i = 1; i <= LAT_DIV; i++) id_pipe_reg[i] <= id_pipe_reg[i-1];
            for (int i = 1; i < LAT_DIV; i++) lt_pipe_reg[i] <= lt_pipe_reg[i-1];
            for (int i = 1; i < LAT_DIV-1; i++) pw_pipe_reg[i] <= pw_pipe_reg[i-1];
        end
    end

    result_t res_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            res_reg.enabled <= id_pipe_reg[LAT_DIV].en;
            res_reg.freq_id <= id_pipe_reg[LAT_DIV].f;
            res_reg.div_id <= id_pipe_reg[LAT_DIV].d;
            res_reg.volt_id <= id_pipe_reg[LAT_DIV].v;
            res_reg.multiplier_x100 <= mult_q;
            res_reg.core_mhz <= mhz_q;
            res_reg.core_mv_x4 <= lt_pipe_reg[LAT_DIV-1].mv;
            res_reg.nb_volt_id <= id_pipe_reg[LAT_DIV].nbv;
            res_reg.nb_mv_x4 <= lt_pipe_reg[LAT_DIV-1].nbmv;
            res_reg.current_x100 <= lt_pipe_reg[LAT_DIV-1].cur;
            res_reg.power_mw <= pw_pipe_reg[LAT_DIV-2];
            res_reg.current_valid <= lt_pipe_reg[LAT_DIV-1].cv;
        end
    end

    assign m_axis_tdata = {1'b0, res_reg.current_valid, res_reg.power_mw,
        res_reg.current_x100, res_reg.nb_mv_x4, res_reg.nb_volt_id,
        res_reg.core_mv_x4, res_reg.core_mhz, res_reg.multiplier_x100,
        res_reg.volt_id, res_reg.div_id, res_reg.freq_id, res_reg.enabled};

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("pipe stalled with empty output");
    a_cur: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !res_reg.current_valid |->
            res_reg.current_x100 == 16'd0 && res_reg.power_mw == 20'd0)
        else $error("current without valid");
endmodule
